// ----- src/rgb_block_max_downscale_assert.svh -----
// ----------------------------------------------------------------------------
// rgb_block_max_downscale assertion macros
// shared assertion forms, clocked on clk and disabled during reset
// ----------------------------------------------------------------------------
`ifndef RGB_BLOCK_MAX_DOWNSCALE_ASSERT_SVH
`define RGB_BLOCK_MAX_DOWNSCALE_ASSERT_SVH

// same-cycle property
`define RBMD_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// antecedent in one cycle, consequent in the next
`define RBMD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- src/rbmd_pkg.sv -----
// ----------------------------------------------------------------------------
// rbmd_pkg
// constants and types shared by the block max downscaler
// ----------------------------------------------------------------------------
package rbmd_pkg;

	// largest image side, sets the line store depth
	localparam int MAX_SIZE  = 1024;
	localparam int IDX_W     = $clog2(MAX_SIZE);
	localparam int CFG_W     = 11;
	localparam int CFG_IDX_W = 1;
	localparam int PIX_W     = 8;
	localparam int ACC_W     = 3 * PIX_W;

	localparam int RST_SIZE  = 64;
	localparam int RST_SCALE = 2;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_IMAGE_SIZE = 1'b0,
		REG_SCALE      = 1'b1
	} cfg_reg_t;

	// one pixel with its position information, ctrl to merge
	typedef struct packed {
		logic [IDX_W-1:0] idx;
		logic             first;
		logic             result;
		logic             eoi;
		logic [PIX_W-1:0] red;
		logic [PIX_W-1:0] green;
		logic [PIX_W-1:0] blue;
	} item_t;

endpackage

// ----- src/rgb_block_max_downscale.sv -----
// ----------------------------------------------------------------------------
// rgb_block_max_downscale
// Max-pooling downscaler for a square RGB image streamed one pixel per
// transfer in raster order. Each scale x scale block gives one pixel holding
// the per-channel maximum, emitted in block raster order when the block's last
// pixel arrives; blocks cut by the image border finish at the border. The
// block takes one pixel per clock sustained while results are taken: every
// pixel costs one read and one write of the line store, the read issued at
// input transfer and the write when the pixel leaves the merge stage, with a
// bypass for the same entry touched by consecutive pixels. A result is loaded
// into an output register when its last pixel leaves the merge stage, so input
// keeps flowing while it waits, until the next block's last pixel reaches the
// merge stage and stalls there. The line store needs no clearing pass after
// reset. Writing either configuration register restarts the image; write only
// while idle.
// ----------------------------------------------------------------------------
module rgb_block_max_downscale (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [rbmd_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  logic [rbmd_pkg::CFG_W-1:0]     cfg_wdata,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [rbmd_pkg::PIX_W-1:0]     red,
	input  logic [rbmd_pkg::PIX_W-1:0]     green,
	input  logic [rbmd_pkg::PIX_W-1:0]     blue,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [rbmd_pkg::PIX_W-1:0]     red_max,
	output logic [rbmd_pkg::PIX_W-1:0]     green_max,
	output logic [rbmd_pkg::PIX_W-1:0]     blue_max,
	output logic                           end_of_image
);
	import rbmd_pkg::*;

	logic             accept;
	item_t            item;
	logic [ACC_W-1:0] rdata;
	logic             we;
	logic [IDX_W-1:0] waddr;
	logic [ACC_W-1:0] wdata;

	assign accept = in_valid && in_ready;

	// position counters and configuration
	rbmd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.accept    (accept),
		.red       (red),
		.green     (green),
		.blue      (blue),
		.item      (item)
	);

	// line store of block accumulators, read at input transfer
	rbmd_ram #(
		.WIDTH (ACC_W),
		.DEPTH (MAX_SIZE)
	) u_line (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (accept),
		.raddr (item.idx),
		.rdata (rdata)
	);

	// merge, write back and output register
	rbmd_merge u_merge (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.item         (item),
		.rdata        (rdata),
		.in_ready     (in_ready),
		.we           (we),
		.waddr        (waddr),
		.wdata        (wdata),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.red_max      (red_max),
		.green_max    (green_max),
		.blue_max     (blue_max),
		.end_of_image (end_of_image)
	);

endmodule

// ----- src/rbmd_ram.sv -----
// ----------------------------------------------------------------------------
// rbmd_ram
// simple dual-port synchronous RAM, one write port, one registered read port
// ----------------------------------------------------------------------------
module rbmd_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read, old data on a same-address write
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- src/rbmd_ctrl.sv -----
// ----------------------------------------------------------------------------
// rbmd_ctrl
// configuration registers and pixel position counters; tags each pixel with
// its line store entry, block start and block end flags
// ----------------------------------------------------------------------------
`include "rgb_block_max_downscale_assert.svh"

module rbmd_ctrl (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [rbmd_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  logic [rbmd_pkg::CFG_W-1:0]    cfg_wdata,
	input  logic                          accept,
	input  logic [rbmd_pkg::PIX_W-1:0]    red,
	input  logic [rbmd_pkg::PIX_W-1:0]    green,
	input  logic [rbmd_pkg::PIX_W-1:0]    blue,
	output rbmd_pkg::item_t               item
);
	import rbmd_pkg::*;

	logic [IDX_W-1:0] nm1_q;
	logic [CFG_W-1:0] sm1_q;
	logic [IDX_W-1:0] col_q;
	logic [IDX_W-1:0] row_q;
	logic [IDX_W-1:0] cib_q;
	logic [IDX_W-1:0] rib_q;

	logic [CFG_W-1:0] n_lim;
	logic [IDX_W-1:0] nm1_d;
	logic [CFG_W-1:0] sm1_d;
	logic             col_last;
	logic             row_last;
	logic             blk_col_end;
	logic             blk_row_end;

	// size and scale kept as last index, zero and oversize cases folded in
	always_comb begin
		n_lim = (int'(cfg_wdata) > MAX_SIZE) ? CFG_W'(MAX_SIZE) : cfg_wdata;
		nm1_d = (cfg_wdata == '0) ? '0 : IDX_W'(n_lim - CFG_W'(1));
		sm1_d = (cfg_wdata == '0) ? '0 : cfg_wdata - CFG_W'(1);
	end

	// position decode
	always_comb begin
		col_last    = (col_q == nm1_q);
		row_last    = (row_q == nm1_q);
		blk_col_end = col_last || (32'(cib_q) == 32'(sm1_q));
		blk_row_end = row_last || (32'(rib_q) == 32'(sm1_q));
		item.idx    = col_q - cib_q;
		item.first  = (cib_q == '0) && (rib_q == '0);
		item.result = blk_col_end && blk_row_end;
		item.eoi    = col_last && row_last;
		item.red    = red;
		item.green  = green;
		item.blue   = blue;
	end

	// config registers and counters; any register write restarts the image
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nm1_q <= IDX_W'(RST_SIZE - 1);
			sm1_q <= CFG_W'(RST_SCALE - 1);
			col_q <= '0;
			row_q <= '0;
			cib_q <= '0;
			rib_q <= '0;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_idx))
				REG_IMAGE_SIZE: nm1_q <= nm1_d;
				REG_SCALE:      sm1_q <= sm1_d;
				default: ;
			endcase
			col_q <= '0;
			row_q <= '0;
			cib_q <= '0;
			rib_q <= '0;
		end else if (accept) begin
			if (col_last) begin
				col_q <= '0;
				cib_q <= '0;
				rib_q <= blk_row_end ? '0 : rib_q + IDX_W'(1);
				row_q <= row_last ? '0 : row_q + IDX_W'(1);
			end else begin
				col_q <= col_q + IDX_W'(1);
				cib_q <= blk_col_end ? '0 : cib_q + IDX_W'(1);
			end
		end
	end

	`RBMD_ASSERT(a_pos_in_image, (col_q <= nm1_q) && (row_q <= nm1_q), "position outside image")
	`RBMD_ASSERT(a_col_in_block, cib_q <= col_q, "column in block beyond column")
	`RBMD_ASSERT(a_row_in_block, rib_q <= row_q, "row in block beyond row")

endmodule

// ----- src/rbmd_merge.sv -----
// ----------------------------------------------------------------------------
// rbmd_merge
// read-modify-write stage on the line store: merges the pixel into its block
// accumulator, forwards a same-entry write, and holds the output register
// ----------------------------------------------------------------------------
`include "rgb_block_max_downscale_assert.svh"

module rbmd_merge (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        accept,
	input  rbmd_pkg::item_t             item,
	input  logic [rbmd_pkg::ACC_W-1:0]  rdata,
	output logic                        in_ready,
	output logic                        we,
	output logic [rbmd_pkg::IDX_W-1:0]  waddr,
	output logic [rbmd_pkg::ACC_W-1:0]  wdata,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [rbmd_pkg::PIX_W-1:0]  red_max,
	output logic [rbmd_pkg::PIX_W-1:0]  green_max,
	output logic [rbmd_pkg::PIX_W-1:0]  blue_max,
	output logic                        end_of_image
);
	import rbmd_pkg::*;

	logic             s1_valid_q;
	item_t            item_s1;
	logic             fwd_hit_s1;
	logic [ACC_W-1:0] fwd_data_s1;

	logic             out_valid_q;
	logic [PIX_W-1:0] red_q;
	logic [PIX_W-1:0] green_q;
	logic [PIX_W-1:0] blue_q;
	logic             eoi_q;

	logic [ACC_W-1:0] old;
	logic [PIX_W-1:0] old_r;
	logic [PIX_W-1:0] old_g;
	logic [PIX_W-1:0] old_b;
	logic [ACC_W-1:0] acc;
	logic             s1_go;

	// accumulator merge, forwarded value wins over the stale read
	always_comb begin
		old   = fwd_hit_s1 ? fwd_data_s1 : rdata;
		old_r = old[3*PIX_W-1:2*PIX_W];
		old_g = old[2*PIX_W-1:PIX_W];
		old_b = old[PIX_W-1:0];
		if (item_s1.first) begin
			acc = {item_s1.red, item_s1.green, item_s1.blue};
		end else begin
			acc = {(old_r > item_s1.red)   ? old_r : item_s1.red,
			       (old_g > item_s1.green) ? old_g : item_s1.green,
			       (old_b > item_s1.blue)  ? old_b : item_s1.blue};
		end
	end

	// stage advance: a block result needs room in the output register
	assign s1_go    = s1_valid_q && (!item_s1.result || !out_valid_q || out_ready);
	assign in_ready = !s1_valid_q || s1_go;

	// write back
	assign we    = s1_go;
	assign waddr = item_s1.idx;
	assign wdata = acc;

	// stage 1 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
			fwd_hit_s1 <= 1'b0;
		end else if (accept) begin
			s1_valid_q <= 1'b1;
			fwd_hit_s1 <= s1_go && (item_s1.idx == item.idx);
		end else if (s1_go) begin
			s1_valid_q <= 1'b0;
		end
	end

	// stage 1 payload
	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1     <= item;
			fwd_data_s1 <= acc;
		end
	end

	// output register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_go && item_s1.result) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (s1_go && item_s1.result) begin
			red_q   <= acc[3*PIX_W-1:2*PIX_W];
			green_q <= acc[2*PIX_W-1:PIX_W];
			blue_q  <= acc[PIX_W-1:0];
			eoi_q   <= item_s1.eoi;
		end
	end

	assign out_valid    = out_valid_q;
	assign red_max      = red_q;
	assign green_max    = green_q;
	assign blue_max     = blue_q;
	assign end_of_image = eoi_q;

	`RBMD_ASSERT(a_no_accept_on_stall, (s1_valid_q && !s1_go) |-> !accept, "accept while stalled")
	`RBMD_ASSERT_NEXT(a_fwd_capture, accept && s1_go && (item_s1.idx == item.idx), fwd_hit_s1 && (fwd_data_s1 == $past(acc)), "same-entry write not forwarded")
	`RBMD_ASSERT(a_no_write_on_full, (s1_valid_q && item_s1.result && out_valid_q && !out_ready) |-> !we, "write while result blocked")

endmodule

// ----- sim/tb_rgb_block_max_downscale.sv -----
// ----------------------------------------------------------------------------
// tb_rgb_block_max_downscale
// Self-checking bench for the max-pooling downscaler. A line-store predictor
// tracks block position and per-column maxima, and each output transfer is
// compared against the oldest predicted pixel. Directed images cover channel
// extremes, clamped sizes, zero scale, edge-cut blocks, single-block images
// and restarts. Random images then run with random gaps on both handshakes.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_rgb_block_max_downscale;
	import rbmd_pkg::*;

	typedef struct {
		logic [PIX_W-1:0] red_max;
		logic [PIX_W-1:0] green_max;
		logic [PIX_W-1:0] blue_max;
		logic             eoi;
	} pooled_px_t;

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_idx   = REG_IMAGE_SIZE;
	logic [CFG_W-1:0]     cfg_wdata = '0;
	logic                 in_valid  = 1'b0;
	logic                 in_ready;
	logic [PIX_W-1:0]     red       = '0;
	logic [PIX_W-1:0]     green     = '0;
	logic [PIX_W-1:0]     blue      = '0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	logic [PIX_W-1:0]     red_max;
	logic [PIX_W-1:0]     green_max;
	logic [PIX_W-1:0]     blue_max;
	logic                 end_of_image;

	// predictor state
	logic [ACC_W-1:0] line_acc [MAX_SIZE];
	int unsigned      col_pos, row_pos, blk_col, blk_row;
	logic [CFG_W-1:0] size_reg  = CFG_W'(RST_SIZE);
	logic [CFG_W-1:0] scale_reg = CFG_W'(RST_SCALE);
	pooled_px_t       pooled_q [$];

	int err_count  = 0;
	bit idle_on    = 1'b1;
	int ready_left = 0;

	rgb_block_max_downscale dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_idx      (cfg_idx),
		.cfg_wdata    (cfg_wdata),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.red          (red),
		.green        (green),
		.blue         (blue),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.red_max      (red_max),
		.green_max    (green_max),
		.blue_max     (blue_max),
		.end_of_image (end_of_image)
	);

	// 10 ns clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// idle length: mostly none or short, now and then long
	function automatic int pick_gap();
		int r;
		if (!idle_on)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// channel value, biased toward the extremes
	function automatic logic [PIX_W-1:0] pick_chan();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0)
			return '0;
		if (r == 1)
			return '1;
		return PIX_W'($urandom_range(0, 255));
	endfunction

	function automatic logic [PIX_W-1:0] max_chan(logic [PIX_W-1:0] a, logic [PIX_W-1:0] b);
		return (a > b) ? a : b;
	endfunction

	task automatic restart_pos();
		col_pos = 0;
		row_pos = 0;
		blk_col = 0;
		blk_row = 0;
	endtask

	// advance the block position by one pixel and queue a finished block
	task automatic pool_pixel(input logic [PIX_W-1:0] r, g, b);
		int unsigned      n, s, idx;
		logic [ACC_W-1:0] acc, old;
		bit               col_last, row_last, blk_col_end, blk_row_end;
		pooled_px_t       px;
		n = 32'(size_reg);
		if (n == 0)
			n = 1;
		if (n > MAX_SIZE)
			n = MAX_SIZE;
		s = (scale_reg == '0) ? 1 : 32'(scale_reg);
		if (col_pos >= n || row_pos >= n)
			restart_pos();

		col_last    = (col_pos == n - 1);
		row_last    = (row_pos == n - 1);
		blk_col_end = col_last || (blk_col == s - 1);
		blk_row_end = row_last || (blk_row == s - 1);

		idx = col_pos - blk_col;
		if (idx >= MAX_SIZE)
			idx = 0;

		// first pixel of a block overwrites its column entry
		if (blk_col == 0 && blk_row == 0) begin
			acc = {r, g, b};
		end else begin
			old = line_acc[idx[IDX_W-1:0]];
			acc = {max_chan(old[23:16], r), max_chan(old[15:8], g), max_chan(old[7:0], b)};
		end
		line_acc[idx[IDX_W-1:0]] = acc;

		if (blk_col_end && blk_row_end) begin
			px.red_max   = acc[23:16];
			px.green_max = acc[15:8];
			px.blue_max  = acc[7:0];
			px.eoi       = col_last && row_last;
			pooled_q     = {pooled_q, px};
		end

		if (col_last) begin
			col_pos = 0;
			blk_col = 0;
			blk_row = blk_row_end ? 0 : blk_row + 1;
			row_pos = row_last ? 0 : row_pos + 1;
		end else begin
			col_pos = col_pos + 1;
			blk_col = blk_col_end ? 0 : blk_col + 1;
		end
	endtask

	task automatic report_mismatch(input string msg);
		err_count++;
		if (err_count <= 100)
			$display("mismatch at %0t: %s", $time, msg);
	endtask

	task automatic check_field(input string name, input logic [PIX_W-1:0] got, exp);
		if (got !== exp)
			report_mismatch($sformatf("%s got %0h expected %0h", name, got, exp));
	endtask

	// one pixel transfer, predicted at the accepting edge
	task automatic send_pixel(input logic [PIX_W-1:0] r, g, b);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		red      <= r;
		green    <= g;
		blue     <= b;
		do
			@(posedge clk);
		while (in_ready !== 1'b1);
		pool_pixel(r, g, b);
	endtask

	// stop input, wait for every pooled pixel, then let the pipeline empty
	task automatic settle();
		in_valid <= 1'b0;
		while (pooled_q.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// write both registers on back-to-back edges
	task automatic write_image_regs(input logic [CFG_W-1:0] size_w, scale_w);
		cfg_we    <= 1'b1;
		cfg_idx   <= REG_IMAGE_SIZE;
		cfg_wdata <= size_w;
		@(posedge clk);
		size_reg = size_w;
		restart_pos();
		cfg_idx   <= REG_SCALE;
		cfg_wdata <= scale_w;
		@(posedge clk);
		scale_reg = scale_w;
		restart_pos();
		cfg_we <= 1'b0;
	endtask

	task automatic send_random_pixels(input int cnt);
		repeat (cnt) send_pixel(pick_chan(), pick_chan(), pick_chan());
	endtask

	// output side: random stalls
	always @(posedge clk) begin
		int gap;
		if (ready_left > 0) begin
			ready_left--;
		end else if (out_ready) begin
			gap = pick_gap();
			if (gap > 0) begin
				out_ready  <= 1'b0;
				ready_left = gap - 1;
			end else begin
				ready_left = $urandom_range(0, 12);
			end
		end else begin
			out_ready  <= 1'b1;
			ready_left = $urandom_range(0, 12);
		end
	end

	// compare each output transfer with the oldest pooled pixel
	always @(posedge clk) begin
		pooled_px_t px;
		if (arst_n && out_valid === 1'b1 && out_ready) begin
			if (pooled_q.size() == 0) begin
				report_mismatch("output transfer with no pooled pixel pending");
			end else begin
				px = pooled_q.pop_front();
				check_field("red_max", red_max, px.red_max);
				check_field("green_max", green_max, px.green_max);
				check_field("blue_max", blue_max, px.blue_max);
				check_field("end_of_image", PIX_W'(end_of_image), PIX_W'(px.eoi));
			end
		end
	end

	// reset settings: two rows of the 64-wide image, then left unfinished
	task automatic test_reset_defaults();
		send_pixel('0, '1, 8'hAA);
		send_pixel('1, '0, 8'h55);
		send_random_pixels(126);
		settle();
	endtask

	// channel extremes, clamped size, zero scale, edge-cut blocks
	task automatic test_block_extremes();
		int i;
		write_image_regs(11'd4, 11'd2);
		for (i = 0; i < 16; i++)
			send_pixel((i == 5) ? 8'hFF : PIX_W'(i * 3), PIX_W'(255 - i * 16),
				i[0] ? 8'hAA : 8'h55);
		settle();
		// zero scale acts as one
		write_image_regs(11'd1, 11'd0);
		send_pixel('0, '0, '0);
		settle();
		// zero size acts as one
		write_image_regs(11'd0, 11'd1);
		send_pixel('1, '1, '1);
		settle();
		// blocks cut short by the border
		write_image_regs(11'd3, 11'd2);
		send_random_pixels(9);
		settle();
	endtask

	// scale larger than size: whole image is one block
	task automatic test_one_block();
		write_image_regs(11'd3, CFG_W'(MAX_SIZE));
		send_random_pixels(9);
		settle();
		write_image_regs(11'd2, 11'h7FF);
		send_random_pixels(8);
		settle();
	endtask

	// partial image, restart by write, then two images back to back
	task automatic test_restart();
		write_image_regs(11'd4, 11'd2);
		send_random_pixels(6);
		settle();
		write_image_regs(11'd4, 11'd2);
		send_random_pixels(32);
		settle();
	endtask

	// size above the line store depth, start of a wide row
	task automatic test_wide_image();
		write_image_regs(11'h7FF, 11'd1);
		send_random_pixels(64);
		settle();
	endtask

	// random sizes and scales, mostly whole images
	task automatic test_random();
		int               sent, n, d, pick, cnt;
		int               divs [$];
		logic [CFG_W-1:0] size_w, scale_w;
		sent = 0;
		while (sent < 480) begin
			idle_on = ($urandom_range(0, 4) != 0);
			pick = $urandom_range(0, 99);
			if (pick < 90)
				size_w = CFG_W'($urandom_range(1, 12));
			else if (pick < 95)
				size_w = '0;
			else
				size_w = CFG_W'($urandom_range(13, 24));
			n = (size_w == '0) ? 1 : int'(size_w);
			divs = {};
			for (d = 1; d <= n; d++)
				if (n % d == 0)
					divs = {divs, d};
			pick = $urandom_range(0, 99);
			if (pick < 70)
				scale_w = CFG_W'(divs[$urandom_range(0, divs.size() - 1)]);
			else if (pick < 78)
				scale_w = '0;
			else if (pick < 84)
				scale_w = '1;
			else if (pick < 88)
				scale_w = CFG_W'(MAX_SIZE);
			else
				scale_w = CFG_W'($urandom_range(1, n + 3));
			pick = $urandom_range(0, 99);
			if (pick < 70)
				cnt = n * n;
			else if (pick < 85)
				cnt = 2 * n * n;
			else
				cnt = $urandom_range(1, n * n);
			if (cnt > 480 - sent)
				cnt = 480 - sent;
			write_image_regs(size_w, scale_w);
			send_random_pixels(cnt);
			settle();
			sent += cnt;
		end
	endtask

	initial begin
		restart_pos();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_defaults();
		test_block_extremes();
		test_one_block();
		test_restart();
		test_wide_image();
		test_random();
		settle();
		if (pooled_q.size() != 0)
			report_mismatch("pooled pixels never delivered");
		if (err_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	// run limit
	initial begin
		#20_000_000;
		$display("status: fail");
		$finish;
	end

endmodule
